/* hw/rtl/gdip_pkg.sv */
// ----------------------------------------------------------------------------
// Grouped decimal integer parser package
// Types, character codes and limits that the parser modules share.
// ----------------------------------------------------------------------------
package gdip_pkg;

  // Character codes
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharComma  = 8'h2C;
  localparam logic [7:0] CharAltSep = 8'hFF;

  // Configuration reset values
  localparam logic [7:0] QuoteReset    = 8'h22;
  localparam logic [7:0] FieldSepReset = 8'h2C;

  // Limits
  localparam logic [4:0]  MaxDigits32 = 5'd10;
  localparam logic [4:0]  MaxDigits64 = 5'd19;
  localparam logic [4:0]  GroupLen    = 5'd3;
  localparam logic [4:0]  CountSat    = 5'd31;
  localparam logic [15:0] ByteCntMax  = 16'hFFFF;
  localparam logic [63:0] MaxVal32    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MaxVal64    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MinVal32    = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MinVal64    = 64'h8000_0000_0000_0000;

  localparam int unsigned QueueDepth = 2;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgWideMode = 2'd0,
    CfgQuote    = 2'd1,
    CfgFieldSep = 2'd2
  } cfg_idx_e;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PhStart  = 5'b00001,
    PhSign   = 5'b00010,
    PhZeros  = 5'b00100,
    PhAfter  = 5'b01000,
    PhDigits = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       wide_mode;
    logic [7:0] quote_byte;
    logic [7:0] field_separator;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       at_end;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] parsed_value;
    logic               ok;
    logic [15:0]        consumed_bytes;
  } out_word_t;

  // Classified byte as it travels from the front end to the parser
  typedef struct packed {
    logic       has;
    logic       is_quote;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_comma;
    logic       is_alt;
    logic       sep_is_comma;
  } cls_t;

endpackage

/* hw/rtl/grouped_decimal_int_parser.sv */
// ----------------------------------------------------------------------------
// Grouped decimal integer parser
// Parses one decimal text field with optional quotes, sign and thousands
// grouping into a signed 32- or 64-bit integer.
// ----------------------------------------------------------------------------
// One byte of the field is taken per word, and the block sustains one word per
// clock while the queue is not full: the front end classifies the byte, a short
// queue holds it, and the back end updates the parse state and the 64-bit
// accumulator (one shift-add) as it pops the word. A result is registered in
// an output register when the word that ends the field is popped and waits
// there; the queue keeps taking words while that register is stalled until it
// fills. Write configuration only while no field is in flight.
module grouped_decimal_int_parser #(
  parameter int unsigned QueueDepth = gdip_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gdip_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdip_pkg::out_word_t out_word_o
);

  gdip_pkg::cfg_t cfg_q, cfg_d;
  gdip_pkg::cls_t cls_in, cls_out;
  logic           q_full, q_empty, q_push, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (gdip_pkg::cfg_idx_e'(cfg_idx_i))
        gdip_pkg::CfgWideMode: cfg_d.wide_mode       = cfg_wdata_i[0];
        gdip_pkg::CfgQuote:    cfg_d.quote_byte      = cfg_wdata_i;
        gdip_pkg::CfgFieldSep: cfg_d.field_separator = cfg_wdata_i;
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide_mode       <= 1'b0;
      cfg_q.quote_byte      <= gdip_pkg::QuoteReset;
      cfg_q.field_separator <= gdip_pkg::FieldSepReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  gdip_front u_front (
    .cfg_i     (cfg_q),
    .in_word_i (in_word_i),
    .cls_o     (cls_in)
  );

  gdip_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (cls_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (cls_out)
  );

  gdip_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wide_mode_i   (cfg_q.wide_mode),
    .entry_valid_i (!q_empty),
    .entry_i       (cls_out),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

endmodule

/* hw/rtl/gdip_front.sv */
// ----------------------------------------------------------------------------
// Grouped decimal integer parser front end
// Classifies each incoming byte against the character set and configuration.
// ----------------------------------------------------------------------------
module gdip_front (
  input  gdip_pkg::cfg_t     cfg_i,
  input  gdip_pkg::in_word_t in_word_i,
  output gdip_pkg::cls_t     cls_o
);

  logic [7:0] b;
  logic       has;

  assign b   = in_word_i.data_byte;
  assign has = ~in_word_i.at_end;

  always_comb begin
    cls_o              = '0;
    cls_o.has          = has;
    cls_o.is_quote     = has && (b == cfg_i.quote_byte);
    cls_o.is_minus     = has && (b == gdip_pkg::CharMinus);
    cls_o.is_plus      = has && (b == gdip_pkg::CharPlus);
    cls_o.is_zero      = has && (b == gdip_pkg::CharZero);
    cls_o.is_digit     = has && (b >= gdip_pkg::CharZero) && (b <= gdip_pkg::CharNine);
    cls_o.digit        = b[3:0];
    cls_o.is_comma     = has && (b == gdip_pkg::CharComma);
    cls_o.is_alt       = has && (b == gdip_pkg::CharAltSep);
    cls_o.sep_is_comma = (cfg_i.field_separator == gdip_pkg::CharComma);
  end

endmodule

/* hw/rtl/gdip_queue.sv */
// ----------------------------------------------------------------------------
// Grouped decimal integer parser queue
// Short FIFO of classified bytes between the front end and the parser.
// ----------------------------------------------------------------------------
module gdip_queue #(
  parameter int unsigned Depth = gdip_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gdip_pkg::cls_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output gdip_pkg::cls_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gdip_pkg::cls_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/gdip_back.sv */
// ----------------------------------------------------------------------------
// Grouped decimal integer parser back end
// Runs the field parse on classified bytes and holds the result word.
// ----------------------------------------------------------------------------
module gdip_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wide_mode_i,
  input  logic                entry_valid_i,
  input  gdip_pkg::cls_t      entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdip_pkg::out_word_t out_word_o
);

  gdip_pkg::phase_e    phase_q, phase_d;
  logic                quoted_q, quoted_d;
  logic                neg_q, neg_d;
  logic [63:0]         acc_q, acc_d;
  logic [4:0]          sig_q, sig_d;
  logic [4:0]          grp_q, grp_d;
  logic [15:0]         cnt_q, cnt_d;
  logic                saw_q, saw_d;
  logic                out_valid_q, out_valid_d;
  gdip_pkg::out_word_t out_word_q, out_word_d;

  logic        cnt_full;
  logic        sep_match;
  logic        alt_sep;
  logic [4:0]  digit_limit;
  logic [63:0] max_val;
  logic [63:0] neg_val;
  logic [63:0] val;
  logic        fin_ok;
  logic [15:0] fin_cnt;

  assign pop_o       = entry_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign cnt_full    = (cnt_q == gdip_pkg::ByteCntMax);
  // Unquoted fields with a comma column separator use 0xFF as group mark.
  assign alt_sep     = !quoted_q && entry_i.sep_is_comma;
  assign sep_match   = alt_sep ? entry_i.is_alt : entry_i.is_comma;
  assign digit_limit = wide_mode_i ? gdip_pkg::MaxDigits64 : gdip_pkg::MaxDigits32;
  assign max_val     = wide_mode_i ? gdip_pkg::MaxVal64 : gdip_pkg::MaxVal32;
  assign neg_val     = neg_q ? (64'd0 - acc_q) : acc_q;
  assign val         = wide_mode_i ? neg_val : {{32{neg_val[31]}}, neg_val[31:0]};

  // Checks made when a byte ends the number.
  always_comb begin
    fin_ok  = 1'b1;
    fin_cnt = cnt_q;
    if (grp_q != gdip_pkg::GroupLen && grp_q != sig_q) begin
      fin_ok = 1'b0;
    end
    if (quoted_q) begin
      if (!entry_i.is_quote || cnt_full) begin
        fin_ok = 1'b0;
      end
      fin_cnt = cnt_q + 16'd1;
    end else if (grp_q != sig_q && alt_sep) begin
      fin_ok = 1'b0;
    end
    if (!(((sig_q != 5'd0) ? (sig_q < digit_limit) : saw_q) ||
          (sig_q == digit_limit && acc_q <= max_val))) begin
      fin_ok = 1'b0;
    end
  end

  always_comb begin
    logic handled;
    logic fail;
    logic finish;
    logic pre_digits;

    phase_d     = phase_q;
    quoted_d    = quoted_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    sig_d       = sig_q;
    grp_d       = grp_q;
    cnt_d       = cnt_q;
    saw_d       = saw_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    handled     = 1'b0;
    fail        = 1'b0;
    finish      = 1'b0;
    pre_digits  = (phase_q == gdip_pkg::PhStart) || (phase_q == gdip_pkg::PhSign) ||
                  (phase_q == gdip_pkg::PhZeros);

    if (pop_o) begin
      if (phase_q == gdip_pkg::PhStart && entry_i.is_quote) begin
        handled = 1'b1;
        if (cnt_full) begin
          fail = 1'b1;
        end else begin
          quoted_d = 1'b1;
          phase_d  = gdip_pkg::PhSign;
          cnt_d    = cnt_q + 16'd1;
        end
      end
      if (!handled && (phase_q == gdip_pkg::PhStart || phase_q == gdip_pkg::PhSign) &&
          (entry_i.is_minus || entry_i.is_plus)) begin
        handled = 1'b1;
        if (cnt_full) begin
          fail = 1'b1;
        end else begin
          neg_d   = entry_i.is_minus;
          phase_d = gdip_pkg::PhZeros;
          cnt_d   = cnt_q + 16'd1;
        end
      end
      if (!handled && pre_digits && entry_i.is_zero) begin
        handled = 1'b1;
        if (cnt_full) begin
          fail = 1'b1;
        end else begin
          saw_d   = 1'b1;
          phase_d = gdip_pkg::PhZeros;
          cnt_d   = cnt_q + 16'd1;
        end
      end
      if (!handled && phase_q == gdip_pkg::PhAfter && sep_match) begin
        handled = 1'b1;
        if (grp_q > gdip_pkg::GroupLen ||
            (grp_q < gdip_pkg::GroupLen && grp_q != sig_q) || cnt_full) begin
          fail = 1'b1;
        end else begin
          grp_d   = 5'd0;
          phase_d = gdip_pkg::PhDigits;
          cnt_d   = cnt_q + 16'd1;
        end
      end
      if (!handled && entry_i.is_digit) begin
        handled = 1'b1;
        if (cnt_full) begin
          fail = 1'b1;
        end else begin
          acc_d   = (acc_q << 3) + (acc_q << 1) + {60'd0, entry_i.digit};
          sig_d   = (sig_q == gdip_pkg::CountSat) ? sig_q : sig_q + 5'd1;
          grp_d   = (grp_q == gdip_pkg::CountSat) ? grp_q : grp_q + 5'd1;
          saw_d   = 1'b1;
          phase_d = gdip_pkg::PhAfter;
          cnt_d   = cnt_q + 16'd1;
        end
      end
      if (!handled) begin
        finish = 1'b1;
      end

      if (fail || finish) begin
        out_valid_d = 1'b1;
        if (finish && fin_ok) begin
          out_word_d.parsed_value   = val;
          out_word_d.ok             = 1'b1;
          out_word_d.consumed_bytes = fin_cnt;
        end else begin
          out_word_d.parsed_value   = wide_mode_i ? gdip_pkg::MinVal64 : gdip_pkg::MinVal32;
          out_word_d.ok             = 1'b0;
          out_word_d.consumed_bytes = 16'd0;
        end
        // Back to the start of a new field; the ending byte is dropped.
        phase_d  = gdip_pkg::PhStart;
        quoted_d = 1'b0;
        neg_d    = 1'b0;
        acc_d    = 64'd0;
        sig_d    = 5'd0;
        grp_d    = 5'd0;
        cnt_d    = 16'd0;
        saw_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= gdip_pkg::PhStart;
      quoted_q    <= 1'b0;
      neg_q       <= 1'b0;
      acc_q       <= 64'd0;
      sig_q       <= 5'd0;
      grp_q       <= 5'd0;
      cnt_q       <= 16'd0;
      saw_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      quoted_q    <= quoted_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      sig_q       <= sig_d;
      grp_q       <= grp_d;
      cnt_q       <= cnt_d;
      saw_q       <= saw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

endmodule

/* hw/rtl/gdip_checker.sv */
// ----------------------------------------------------------------------------
// Grouped decimal integer parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module gdip_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input gdip_pkg::out_word_t out_word_o
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A failed parse reports no consumed bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.ok |-> out_word_o.consumed_bytes == 16'd0)
    else $error("failure with nonzero byte count");

  // A failed parse reports the minimum of either width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.ok |->
      out_word_o.parsed_value[63] && out_word_o.parsed_value[30:0] == 31'd0)
    else $error("failure value is not a width minimum");

  // A successful parse always reports at least one consumed byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.ok |-> out_word_o.consumed_bytes != 16'd0)
    else $error("success with no bytes consumed");

endmodule

bind grouped_decimal_int_parser gdip_checker u_gdip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
